// File: rtl/load_watermark_freq_governor_core_macros.svh
// assertion helpers shared by the governor rtl
`ifndef LOAD_WATERMARK_FREQ_GOVERNOR_CORE_MACROS_SVH
`define LOAD_WATERMARK_FREQ_GOVERNOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LWFG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lwfg assertion failed");

// next-cycle implication, disabled while in reset
`define LWFG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lwfg assertion failed");

`endif

// File: rtl/lwfg_pkg.sv
package lwfg_pkg;

    localparam int LEVELS       = 16;
    localparam int LEVEL_W      = $clog2(LEVELS);
    localparam int NUM_LEVELS_W = 5;
    localparam int LVL_CMP_W    = ((LEVEL_W > NUM_LEVELS_W) ? LEVEL_W : NUM_LEVELS_W) + 1;

    localparam int DSP_W     = 15;
    localparam int MARK_W    = 7;
    localparam int MARK_SHIFT = 8;
    localparam int CNT_W     = 64;
    localparam int NCNT      = 7;
    localparam int PROD_W    = CNT_W + MARK_W;
    localparam int CHG_W     = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [MARK_W-1:0] BUSY_SCALE = MARK_W'(100);

    localparam int QDEPTH  = 16;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    // pipeline depth of the front part
    localparam int FRONT_STAGES = 6;

    // counter order inside the delta array
    localparam int CNT_USER    = 0;
    localparam int CNT_NICE    = 1;
    localparam int CNT_SYSTEM  = 2;
    localparam int CNT_IDLE    = 3;
    localparam int CNT_IOWAIT  = 4;
    localparam int CNT_IRQ     = 5;
    localparam int CNT_SOFTIRQ = 6;

    localparam logic [MARK_W-1:0]       RST_DSP_HIGH   = MARK_W'(50);
    localparam logic [MARK_W-1:0]       RST_DSP_LOW    = MARK_W'(10);
    localparam logic [MARK_W-1:0]       RST_CPU_HIGH   = MARK_W'(80);
    localparam logic [MARK_W-1:0]       RST_CPU_LOW    = MARK_W'(20);
    localparam logic                    RST_USE_CPU    = 1'b0;
    localparam logic                    RST_IGN_NICE   = 1'b1;
    localparam logic [NUM_LEVELS_W-1:0] RST_NUM_LEVELS = NUM_LEVELS_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DSP_HIGH   = 3'd0,
        CFG_DSP_LOW    = 3'd1,
        CFG_CPU_HIGH   = 3'd2,
        CFG_CPU_LOW    = 3'd3,
        CFG_USE_CPU    = 3'd4,
        CFG_IGN_NICE   = 3'd5,
        CFG_NUM_LEVELS = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_LOWER = 2'd0,
        ACT_SAME  = 2'd1,
        ACT_RAISE = 2'd2
    } action_t;

    typedef struct packed {
        logic [DSP_W-1:0] dsp_load;
        logic [CNT_W-1:0] user_ticks;
        logic [CNT_W-1:0] nice_ticks;
        logic [CNT_W-1:0] system_ticks;
        logic [CNT_W-1:0] idle_ticks;
        logic [CNT_W-1:0] iowait_ticks;
        logic [CNT_W-1:0] irq_ticks;
        logic [CNT_W-1:0] softirq_ticks;
    } in_item_t;

    typedef struct packed {
        action_t            action;
        logic [LEVEL_W-1:0] level;
        logic [CHG_W-1:0]   change_count;
    } out_item_t;

    typedef struct packed {
        logic [MARK_W-1:0]       dsp_high_mark;
        logic [MARK_W-1:0]       dsp_low_mark;
        logic [MARK_W-1:0]       cpu_high_mark;
        logic [MARK_W-1:0]       cpu_low_mark;
        logic                    cpu_load_en;
        logic                    nice_excl;
        logic [NUM_LEVELS_W-1:0] num_levels;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic raise;
        logic lower;
    } req_t;

endpackage

// File: rtl/lwfg_front.sv
module lwfg_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  lwfg_pkg::in_item_t in_item,
    input  lwfg_pkg::cfg_t    cfg,
    output logic              push_valid,
    output lwfg_pkg::req_t    push_req
);
    import lwfg_pkg::*;

    logic [CNT_W-1:0] cnt_in [NCNT];
    logic [CNT_W-1:0] prev_reg [NCNT];
    logic [CNT_W-1:0] d_reg [NCNT];

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] dhi_reg;
    logic [FRONT_STAGES-1:0] dlo_reg;
    logic            dsp_hi, dsp_lo;

    logic [CNT_W-1:0]  s2_us_reg, s2_irq_reg, s2_idl_reg, s2_nice_reg;
    logic [CNT_W-1:0]  s3_ab_reg, s3_cn_reg, s3_nice_reg;
    logic [CNT_W-1:0]  s4_busy_reg, s4_total_reg;
    logic [PROD_W-1:0] s5_pb_reg, s5_ph_reg, s5_pl_reg;
    logic              s5_zero_reg;
    logic              cpu_hi, cpu_lo;
    req_t              s6_req_reg, s6_req_next;

    assign cnt_in[CNT_USER]    = in_item.user_ticks;
    assign cnt_in[CNT_NICE]    = in_item.nice_ticks;
    assign cnt_in[CNT_SYSTEM]  = in_item.system_ticks;
    assign cnt_in[CNT_IDLE]    = in_item.idle_ticks;
    assign cnt_in[CNT_IOWAIT]  = in_item.iowait_ticks;
    assign cnt_in[CNT_IRQ]     = in_item.irq_ticks;
    assign cnt_in[CNT_SOFTIRQ] = in_item.softirq_ticks;

    assign dsp_hi = in_item.dsp_load > (DSP_W'(cfg.dsp_high_mark) << MARK_SHIFT);
    assign dsp_lo = in_item.dsp_load < (DSP_W'(cfg.dsp_low_mark) << MARK_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            for (int i = 0; i < NCNT; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_fire};
            if (in_fire && cfg.cpu_load_en) begin
                for (int i = 0; i < NCNT; i++) begin
                    prev_reg[i] <= cnt_in[i];
                end
            end
        end
    end

    // datapath stages, no reset needed
    always_ff @(posedge aclk) begin
        dhi_reg <= {dhi_reg[FRONT_STAGES-2:0], dsp_hi};
        dlo_reg <= {dlo_reg[FRONT_STAGES-2:0], dsp_lo};
        for (int i = 0; i < NCNT; i++) begin
            d_reg[i] <= cnt_in[i] - prev_reg[i];
        end
        s2_us_reg   <= d_reg[CNT_USER] + d_reg[CNT_SYSTEM];
        s2_irq_reg  <= d_reg[CNT_IRQ] + d_reg[CNT_SOFTIRQ];
        s2_idl_reg  <= d_reg[CNT_IDLE] + d_reg[CNT_IOWAIT];
        s2_nice_reg <= d_reg[CNT_NICE];
        s3_ab_reg   <= s2_us_reg + s2_irq_reg;
        s3_cn_reg   <= s2_idl_reg + s2_nice_reg;
        s3_nice_reg <= s2_nice_reg;
        s4_busy_reg <= s3_ab_reg + (cfg.nice_excl ? '0 : s3_nice_reg);
        s4_total_reg <= s3_ab_reg + s3_cn_reg;
        s5_pb_reg   <= PROD_W'(s4_busy_reg) * PROD_W'(BUSY_SCALE);
        s5_ph_reg   <= PROD_W'(s4_total_reg) * PROD_W'(cfg.cpu_high_mark);
        s5_pl_reg   <= PROD_W'(s4_total_reg) * PROD_W'(cfg.cpu_low_mark);
        s5_zero_reg <= (s4_total_reg == '0);
        s6_req_reg  <= s6_req_next;
    end

    always_comb begin
        if (cfg.cpu_load_en) begin
            cpu_hi = !s5_zero_reg && (s5_pb_reg >= s5_ph_reg);
            cpu_lo = !s5_zero_reg && (s5_pb_reg <= s5_pl_reg);
        end else begin
            cpu_hi = 1'b0;
            cpu_lo = 1'b1;
        end
        s6_req_next.raise = dhi_reg[FRONT_STAGES-2] || cpu_hi;
        s6_req_next.lower = dlo_reg[FRONT_STAGES-2] && cpu_lo;
    end

    assign push_valid = vld_reg[FRONT_STAGES-1];
    assign push_req   = s6_req_reg;

endmodule

// File: rtl/lwfg_queue.sv
module lwfg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lwfg_pkg::req_t push_req,
    input  logic           pop,
    output logic           pop_valid,
    output lwfg_pkg::req_t pop_req,
    output logic           full
);
    import lwfg_pkg::*;

    req_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign pop_valid = (cnt_reg != '0);
    assign pop_req   = mem_reg[rd_ptr_reg];
    assign full      = (cnt_reg == QCNT_W'(QDEPTH));

endmodule

// File: rtl/lwfg_back.sv
module lwfg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  lwfg_pkg::req_t     q_req,
    output logic               q_pop,
    input  lwfg_pkg::cfg_t     cfg,
    output logic               m_valid,
    input  logic               m_ready,
    output lwfg_pkg::out_item_t m_data
);
    import lwfg_pkg::*;

    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [CHG_W-1:0]     count_reg, count_next;
    action_t              act;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;
    logic [LVL_CMP_W-1:0] n_ext, n_clamp, last;

    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    always_comb begin
        n_ext = LVL_CMP_W'(cfg.num_levels);
        priority if (n_ext == '0) begin
            n_clamp = LVL_CMP_W'(1);
        end else if (n_ext > LVL_CMP_W'(LEVELS)) begin
            n_clamp = LVL_CMP_W'(LEVELS);
        end else begin
            n_clamp = n_ext;
        end
        last = n_clamp - LVL_CMP_W'(1);

        level_next = level_reg;
        count_next = count_reg;
        act        = ACT_SAME;
        // raise wins over lower when marks are inverted, unless the level is already 0
        priority if (q_req.raise && level_reg != '0) begin
            level_next = '0;
            count_next = count_reg + CHG_W'(1);
            act        = ACT_RAISE;
        end else if (q_req.lower && (LVL_CMP_W'(level_reg) < last)) begin
            level_next = level_reg + LEVEL_W'(1);
            count_next = count_reg + CHG_W'(1);
            act        = ACT_LOWER;
        end else begin
            act        = ACT_SAME;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                level_reg     <= level_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_data_reg.action       <= act;
            out_data_reg.level        <= level_next;
            out_data_reg.change_count <= count_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: rtl/load_watermark_freq_governor_core.sv
// Load watermark frequency governor.
// s_ channel: one poll tick per transfer (DSP load and seven cumulative tick
// counters). m_ channel: one decision per tick (action, level after the tick,
// running change count), in tick order.
// cfg_we/cfg_index/cfg_data write one of the seven setup registers per cycle;
// write them only while no tick is in flight.
// A tick's decision passes the six front stages, the queue and the output
// register in that order; it waits in the queue while the output register is full.
// Throughput: one tick per cycle while m_ready stays high. The front is a six-stage
// pipeline (counter deltas, two adder levels, busy/total sums, 64x7 products,
// compare); a 16-entry queue sits between it and the level update.
// The front admits a tick only while pipeline plus queue hold fewer than 16,
// so a stalled receiver fills the queue and then drops s_ready; the level
// unit waits on the output register while the front keeps draining into the queue.
// Reset (aresetn low, synchronous) loads register defaults, clears the stored
// counters, level 0 (fastest), change count 0, and empties pipeline and queue.
`include "load_watermark_freq_governor_core_macros.svh"

module load_watermark_freq_governor_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  lwfg_pkg::in_item_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output lwfg_pkg::out_item_t                    m_data,
    input  logic                                   cfg_we,
    input  logic [lwfg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lwfg_pkg::CFG_W-1:0]             cfg_data
);
    import lwfg_pkg::*;

    cfg_t              cfg_reg;
    logic [QCNT_W-1:0] occ_reg, occ_next;
    logic              s_fire;
    logic              push_valid;
    req_t              push_req;
    logic              q_valid, q_pop, q_full;
    req_t              q_req;

    assign s_ready = (occ_reg < QCNT_W'(QDEPTH));
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dsp_high_mark <= RST_DSP_HIGH;
            cfg_reg.dsp_low_mark  <= RST_DSP_LOW;
            cfg_reg.cpu_high_mark <= RST_CPU_HIGH;
            cfg_reg.cpu_low_mark  <= RST_CPU_LOW;
            cfg_reg.cpu_load_en   <= RST_USE_CPU;
            cfg_reg.nice_excl     <= RST_IGN_NICE;
            cfg_reg.num_levels    <= RST_NUM_LEVELS;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DSP_HIGH:   cfg_reg.dsp_high_mark <= cfg_data[MARK_W-1:0];
                CFG_DSP_LOW:    cfg_reg.dsp_low_mark  <= cfg_data[MARK_W-1:0];
                CFG_CPU_HIGH:   cfg_reg.cpu_high_mark <= cfg_data[MARK_W-1:0];
                CFG_CPU_LOW:    cfg_reg.cpu_low_mark  <= cfg_data[MARK_W-1:0];
                CFG_USE_CPU:    cfg_reg.cpu_load_en   <= cfg_data[0];
                CFG_IGN_NICE:   cfg_reg.nice_excl     <= cfg_data[0];
                CFG_NUM_LEVELS: cfg_reg.num_levels    <= cfg_data[NUM_LEVELS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ticks in the front pipeline plus entries in the queue
    always_comb begin
        occ_next = occ_reg;
        if (s_fire && !q_pop) begin
            occ_next = occ_reg + QCNT_W'(1);
        end else if (q_pop && !s_fire) begin
            occ_next = occ_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    lwfg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (s_fire),
        .in_item    (s_data),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_req   (push_req)
    );

    lwfg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_req  (push_req),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_req   (q_req),
        .full      (q_full)
    );

    lwfg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `LWFG_ASSERT_IMP(a_occ_bound, 1'b1, occ_reg <= QCNT_W'(QDEPTH))
    `LWFG_ASSERT_IMP(a_no_overflow, push_valid, !q_full)
    `LWFG_ASSERT_IMP(a_pop_counted, q_pop, occ_reg != '0)
    `LWFG_ASSERT_IMP(a_raise_fastest, m_valid && m_data.action == ACT_RAISE, m_data.level == '0)

endmodule
